// ----- rtl/dws_pkg.sv -----
`timescale 1ns / 1ps

package dws_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 3;

    // request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LENGTH     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load_back;
    } cell_ctrl_t;

endpackage

// ----- rtl/dws_cell.sv -----
`timescale 1ns / 1ps

module dws_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                       clk,
    input  dws_pkg::cell_ctrl_t        ctrl,
    input  logic [CW-1:0]              count,
    input  logic [dws_pkg::WORD_W-1:0] word,
    input  logic [dws_pkg::WORD_W-1:0] left_word,
    input  logic [dws_pkg::WORD_W-1:0] right_word,
    output logic [dws_pkg::WORD_W-1:0] data,
    output logic                       match,
    output logic                       tail
);

    logic [dws_pkg::WORD_W-1:0] entry_reg;
    logic [dws_pkg::WORD_W-1:0] entry_next;
    logic                       live;

    assign live  = count > CW'(IDX);
    assign match = live && (entry_reg == word);
    assign tail  = count == CW'(IDX + 1);
    assign data  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_right)
        begin
            entry_next = left_word;
        end
        else if (ctrl.shift_left)
        begin
            entry_next = right_word;
        end
        else if (ctrl.load_back && (count == CW'(IDX)))
        begin
            entry_next = word;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/deque_with_search.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+----------------------------------
// request   | in        | in_valid / in_ready | mode, value
// result    | out       | out_valid/out_ready | result_value, position, status
//
// one request per cycle; its result is registered and appears the cycle after
// acceptance. in_ready is high while the result register is empty or being taken.
// a search compares the key in every cell at once; the priority pick of the first
// match across the row of cells sets the longest path.
// rst_n clears the length count and the result valid flag; the cells hold no reset
// value and are only read below the count.
// a stalled result holds the request side off; nothing is dropped.

module deque_with_search #(
    parameter int CAPACITY = dws_pkg::DEFAULT_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dws_pkg::MODE_W-1:0]          mode,
    input  logic signed [dws_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dws_pkg::WORD_W-1:0]   result_value,
    output logic [dws_pkg::POS_W-1:0]           position,
    output logic [dws_pkg::STATUS_W-1:0]        status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    // length of the stored sequence
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [dws_pkg::WORD_W-1:0]      result_value_reg;
    logic [dws_pkg::WORD_W-1:0]      result_value_next;
    logic [dws_pkg::POS_W-1:0]       position_reg;
    logic [dws_pkg::POS_W-1:0]       position_next;
    logic [dws_pkg::STATUS_W-1:0]    status_reg;
    logic [dws_pkg::STATUS_W-1:0]    status_next;

    logic                            accept;
    logic                            full;
    logic                            empty;
    dws_pkg::cell_ctrl_t             ctrl;

    // row of cells
    logic [dws_pkg::WORD_W-1:0]      cell_data [CAPACITY];
    logic [CAPACITY-1:0]             cell_match;
    logic [CAPACITY-1:0]             cell_tail;

    logic                            hit;
    logic [IW-1:0]                   hit_idx;
    logic [dws_pkg::WORD_W-1:0]      tail_word;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CAP_COUNT;
    assign empty    = count_reg == '0;

    // cell 0 takes the pushed word on a shift towards the back; the last cell
    // keeps its own word on a shift towards the front
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [dws_pkg::WORD_W-1:0] left_w;
            logic [dws_pkg::WORD_W-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = value;
            end
            else
            begin : g_inner_l
                assign left_w = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_data[g];
            end
            else
            begin : g_inner_r
                assign right_w = cell_data[g+1];
            end

            dws_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .word       (value),
                .left_word  (left_w),
                .right_word (right_w),
                .data       (cell_data[g]),
                .match      (cell_match[g]),
                .tail       (cell_tail[g])
            );
        end
    endgenerate

    // first matching cell from the front wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // tail cell is one-hot, so an and-or picks its word
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_word = tail_word | ({dws_pkg::WORD_W{cell_tail[i]}} & cell_data[i]);
        end
    end

    // request decode
    always_comb
    begin
        ctrl              = '0;
        count_next        = count_reg;
        result_value_next = '0;
        position_next     = '0;
        status_next       = dws_pkg::ST_OK;

        case (mode)
            dws_pkg::MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = dws_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.shift_right = 1'b1;
                    count_next       = count_reg + 1'b1;
                end
            end
            dws_pkg::MODE_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = dws_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.load_back = 1'b1;
                    count_next     = count_reg + 1'b1;
                end
            end
            dws_pkg::MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = dws_pkg::ST_EMPTY;
                end
                else
                begin
                    result_value_next = cell_data[0];
                    ctrl.shift_left   = 1'b1;
                    count_next        = count_reg - 1'b1;
                end
            end
            dws_pkg::MODE_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = dws_pkg::ST_EMPTY;
                end
                else
                begin
                    result_value_next = tail_word;
                    count_next        = count_reg - 1'b1;
                end
            end
            dws_pkg::MODE_SEARCH:
            begin
                if (hit)
                begin
                    position_next = dws_pkg::POS_W'(hit_idx);
                end
                else
                begin
                    status_next = dws_pkg::ST_NOT_FOUND;
                end
            end
            dws_pkg::MODE_LENGTH:
            begin
                position_next = dws_pkg::POS_W'(count_reg);
            end
            dws_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused code: no effect, all-zero result
            end
        endcase

        // nothing moves without an accepted request
        if (!accept)
        begin
            ctrl       = '0;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_value_reg <= result_value_next;
            position_reg     <= position_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign position     = position_reg;
    assign status       = status_reg;

    // length never runs past the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("length count above capacity");

    // a push into a full store is refused and leaves the length alone
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full &&
        (mode == dws_pkg::MODE_PUSH_FRONT || mode == dws_pkg::MODE_PUSH_BACK)
        |=> status == dws_pkg::ST_FULL && count_reg == $past(count_reg))
        else $error("full push not rejected");

    // a pop from a non-empty store shortens it by one
    a_pop_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !empty &&
        (mode == dws_pkg::MODE_POP_FRONT || mode == dws_pkg::MODE_POP_BACK)
        |=> count_reg == $past(count_reg) - 1'b1 && status == dws_pkg::ST_OK)
        else $error("pop did not shorten the store");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dws_pkg::ST_NOT_FOUND |-> position == '0)
        else $error("search miss with non-zero position");

endmodule

// ----- bench/deque_checker.sv -----
`timescale 1ns / 1ps

module deque_checker #(
    parameter int CAPACITY = dws_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [dws_pkg::MODE_W-1:0]        mode,
    input  logic signed [dws_pkg::WORD_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [dws_pkg::WORD_W-1:0] result_value,
    input  logic [dws_pkg::POS_W-1:0]         position,
    input  logic [dws_pkg::STATUS_W-1:0]      status,
    output int                                mismatches,
    output int                                outstanding,
    output int                                results_seen,
    output int                                full_rejects,
    output int                                empty_pops,
    output int                                search_hits,
    output int                                search_misses
);

    typedef struct packed {
        logic [dws_pkg::MODE_W-1:0]   op;
        logic [dws_pkg::WORD_W-1:0]   word;
        logic [dws_pkg::POS_W-1:0]    pos;
        logic [dws_pkg::STATUS_W-1:0] st;
    } deque_reply_t;

    deque_reply_t               awaited_replies[$];
    logic [dws_pkg::WORD_W-1:0] shadow_cells [CAPACITY];
    int                         shadow_len;

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        results_seen  = 0;
        full_rejects  = 0;
        empty_pops    = 0;
        search_hits   = 0;
        search_misses = 0;
        shadow_len    = 0;
    end

    // updates the shadow deque and returns the reply the block owes
    function automatic deque_reply_t predict_reply(input logic [dws_pkg::MODE_W-1:0] m,
                                                   input logic [dws_pkg::WORD_W-1:0] w);
        deque_reply_t r;
        int           i;
        r    = '0;
        r.op = m;
        r.st = dws_pkg::ST_OK;
        case (m)
            dws_pkg::MODE_PUSH_FRONT:
                if (shadow_len >= CAPACITY)
                    r.st = dws_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_len; i > 0; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[0] = w;
                    shadow_len++;
                end
            dws_pkg::MODE_PUSH_BACK:
                if (shadow_len >= CAPACITY)
                    r.st = dws_pkg::ST_FULL;
                else
                begin
                    shadow_cells[shadow_len] = w;
                    shadow_len++;
                end
            dws_pkg::MODE_POP_FRONT:
                if (shadow_len == 0)
                    r.st = dws_pkg::ST_EMPTY;
                else
                begin
                    r.word = shadow_cells[0];
                    for (i = 0; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
            dws_pkg::MODE_POP_BACK:
                if (shadow_len == 0)
                    r.st = dws_pkg::ST_EMPTY;
                else
                begin
                    shadow_len--;
                    r.word = shadow_cells[shadow_len];
                end
            dws_pkg::MODE_SEARCH:
            begin
                r.st = dws_pkg::ST_NOT_FOUND;
                for (i = 0; i < shadow_len && r.st == dws_pkg::ST_NOT_FOUND; i++)
                    if (shadow_cells[i] == w)
                    begin
                        r.st  = dws_pkg::ST_OK;
                        r.pos = i[dws_pkg::POS_W-1:0];
                    end
            end
            dws_pkg::MODE_LENGTH:
                r.pos = shadow_len[dws_pkg::POS_W-1:0];
            dws_pkg::MODE_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [dws_pkg::WORD_W-1:0] got,
                                   input logic [dws_pkg::WORD_W-1:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        deque_reply_t due;
        if (rst_n)
        begin
            // a result is registered, so it always leaves after its request; compare first
            if (out_valid && out_ready)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch("result with no request pending", result_value, '0);
                else
                begin
                    due = awaited_replies.pop_front();
                    if (result_value !== due.word)
                        report_mismatch("result_value", result_value, due.word);
                    if (position !== due.pos)
                        report_mismatch("position", dws_pkg::WORD_W'(position),
                                        dws_pkg::WORD_W'(due.pos));
                    if (status !== due.st)
                        report_mismatch("status", dws_pkg::WORD_W'(status),
                                        dws_pkg::WORD_W'(due.st));
                    results_seen++;
                    if (due.st == dws_pkg::ST_FULL)
                        full_rejects++;
                    if (due.st == dws_pkg::ST_EMPTY)
                        empty_pops++;
                    if (due.op == dws_pkg::MODE_SEARCH && due.st == dws_pkg::ST_OK)
                        search_hits++;
                    if (due.st == dws_pkg::ST_NOT_FOUND)
                        search_misses++;
                end
            end
            if (in_valid && in_ready)
                awaited_replies.push_back(predict_reply(mode, value));
            outstanding = awaited_replies.size();
        end
    end

endmodule

// ----- bench/tb_deque_with_search.sv -----
`timescale 1ns / 1ps

module tb_deque_with_search;

    localparam int CAPACITY     = dws_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 250000;

    // selector the block leaves unused; it must answer with all fields zero
    localparam logic [dws_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [dws_pkg::MODE_W-1:0]        mode      = dws_pkg::MODE_LENGTH;
    logic signed [dws_pkg::WORD_W-1:0] value     = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [dws_pkg::WORD_W-1:0] result_value;
    logic [dws_pkg::POS_W-1:0]         position;
    logic [dws_pkg::STATUS_W-1:0]      status;

    int mismatches;
    int outstanding;
    int results_seen;
    int full_rejects;
    int empty_pops;
    int search_hits;
    int search_misses;

    // handshake pacing flags, changed per episode by the stimulus
    bit send_eager       = 1'b0;
    bit take_eager       = 1'b0;
    bit hold_off_pending = 1'b0;

    int sent_count  = 0;
    int cycle_count = 0;

    // small pool of keys so that duplicates, first-match and search hits are common
    logic [dws_pkg::WORD_W-1:0] key_pool [8];

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    deque_with_search #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .position     (position),
        .status       (status)
    );

    deque_checker #(
        .CAPACITY (CAPACITY)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .position      (position),
        .status        (status),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .full_rejects  (full_rejects),
        .empty_pops    (empty_pops),
        .search_hits   (search_hits),
        .search_misses (search_misses)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped by watchdog after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // wait drawn per request or result; mostly short, now and then longer
    function automatic int draw_wait(input bit eager);
        if (eager)
            return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
    endfunction

    // half the words come from the key pool, the rest are raw 32-bit noise
    function automatic logic [dws_pkg::WORD_W-1:0] draw_word();
        if ($urandom_range(0, 1) == 0)
            return key_pool[3'($urandom_range(0, 7))];
        return $urandom();
    endfunction

    // offer one request and return at the edge that accepts it; valid stays
    // high into the next request when no gap is drawn
    task automatic send_request(input logic [dws_pkg::MODE_W-1:0] m,
                                input logic [dws_pkg::WORD_W-1:0] w);
        int gap;
        gap = draw_wait(send_eager);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // sender pause: nothing offered until every result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // result side: one drawn stall per result, plus a single long hold-off on request
    initial
    begin : result_taker
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                // block fills its result register and must stall the request side
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_pending = 1'b0;
            end
            stall = draw_wait(take_eager);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int directed_total;
        int burst;
        int pick;
        bit hold_asked;
        bit pause_done;
        logic [dws_pkg::MODE_W-1:0] m;

        hold_asked  = 1'b0;
        pause_done  = 1'b0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int k = 4; k < 8; k++)
            key_pool[k] = $urandom();

        // reset held from the start, then released once
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store behaviour
        send_request(dws_pkg::MODE_POP_FRONT, 32'h1234_5678);
        send_request(dws_pkg::MODE_POP_BACK, 32'h0);
        send_request(dws_pkg::MODE_SEARCH, 32'h0);

        // extremes of the word pushed at both ends
        send_request(dws_pkg::MODE_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(dws_pkg::MODE_PUSH_FRONT, 32'h8000_0000);
        send_request(dws_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(dws_pkg::MODE_PUSH_FRONT, 32'h5555_5555);
        send_request(dws_pkg::MODE_PUSH_BACK, 32'hAAAA_AAAA);
        send_request(dws_pkg::MODE_PUSH_FRONT, 32'h0000_0000);

        // unused selector changes nothing
        send_request(MODE_UNUSED, 32'hFFFF_FFFF);

        // fill up to capacity, alternating ends
        for (int k = 6; k < CAPACITY; k++)
            send_request((k % 2) ? dws_pkg::MODE_PUSH_FRONT : dws_pkg::MODE_PUSH_BACK,
                         $urandom());

        // push into a full store from both sides
        send_request(dws_pkg::MODE_PUSH_FRONT, 32'h0BAD_F00D);
        send_request(dws_pkg::MODE_PUSH_BACK, 32'h0BAD_F00D);

        // search hits deep in the store and a miss, then length at full
        send_request(dws_pkg::MODE_SEARCH, 32'h8000_0000);
        send_request(dws_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
        send_request(dws_pkg::MODE_SEARCH, 32'h0BAD_F00D);
        send_request(dws_pkg::MODE_LENGTH, 32'h0);

        send_request(dws_pkg::MODE_POP_FRONT, 32'h0);
        send_request(dws_pkg::MODE_POP_BACK, 32'h0);
        send_request(dws_pkg::MODE_CLEAR, 32'h0);
        send_request(dws_pkg::MODE_LENGTH, 32'h0);

        directed_total = sent_count;

        // random episodes: fill runs, drain runs and mixed traffic
        while (sent_count < directed_total + RANDOM_ITEMS)
        begin
            send_eager = ($urandom_range(0, 3) == 0);
            take_eager = ($urandom_range(0, 3) == 0);

            if (!hold_asked && sent_count > directed_total + 300)
            begin
                // keep offering back to back while results are held back
                hold_asked       = 1'b1;
                send_eager       = 1'b1;
                hold_off_pending = 1'b1;
            end
            if (!pause_done && sent_count > directed_total + 700)
            begin
                pause_done = 1'b1;
                wait_for_results();
            end

            case ($urandom_range(0, 2))
                0:
                begin
                    // fill past capacity with searches sprinkled in
                    burst = $urandom_range(CAPACITY / 2, CAPACITY + 6);
                    repeat (burst)
                    begin
                        m = ($urandom_range(0, 1) == 0) ? dws_pkg::MODE_PUSH_FRONT
                                                        : dws_pkg::MODE_PUSH_BACK;
                        send_request(m, draw_word());
                        if ($urandom_range(0, 3) == 0)
                            send_request(dws_pkg::MODE_SEARCH, draw_word());
                    end
                end
                1:
                begin
                    // drain past empty with the odd length query
                    burst = $urandom_range(CAPACITY / 2, CAPACITY + 4);
                    repeat (burst)
                    begin
                        m = ($urandom_range(0, 1) == 0) ? dws_pkg::MODE_POP_FRONT
                                                        : dws_pkg::MODE_POP_BACK;
                        send_request(m, $urandom());
                        if ($urandom_range(0, 4) == 0)
                            send_request(dws_pkg::MODE_LENGTH, $urandom());
                    end
                end
                default:
                begin
                    // mixed traffic; clear and the unused selector kept rare
                    repeat (30)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 22)
                            m = dws_pkg::MODE_PUSH_FRONT;
                        else if (pick < 44)
                            m = dws_pkg::MODE_PUSH_BACK;
                        else if (pick < 58)
                            m = dws_pkg::MODE_POP_FRONT;
                        else if (pick < 72)
                            m = dws_pkg::MODE_POP_BACK;
                        else if (pick < 88)
                            m = dws_pkg::MODE_SEARCH;
                        else if (pick < 95)
                            m = dws_pkg::MODE_LENGTH;
                        else if (pick < 98)
                            m = dws_pkg::MODE_CLEAR;
                        else
                            m = MODE_UNUSED;
                        send_request(m, draw_word());
                    end
                end
            endcase
        end

        // drain and let the result register settle
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("run covered %0d requests, %0d results checked,", sent_count, results_seen);
        $display("%0d full-store pushes, %0d empty pops, searches: %0d hits, %0d misses",
                 full_rejects, empty_pops, search_hits, search_misses);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
